@@ src/running_stats_outlier_test_assert.svh @@
// Assertion macros shared by the checker of the running statistics outlier test.
`ifndef RUNNING_STATS_OUTLIER_TEST_ASSERT_SVH
`define RUNNING_STATS_OUTLIER_TEST_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define RSOT_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("rsot check failed");

// Consequent must hold in the cycle after the antecedent.
`define RSOT_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("rsot check failed");

`endif

@@ src/rsot_pkg.sv @@
// Shared types and constants of the running statistics outlier test.
package rsot_pkg;

	localparam int NUM_CLASSES = 16;
	localparam int CNT_DEPTH   = NUM_CLASSES * 2;
	localparam int CNT_AW      = $clog2(CNT_DEPTH);

	localparam int IN_TDATA_W  = 40;
	localparam int OUT_TDATA_W = 136;

	localparam logic [1:0] ACT_CLEAR  = 2'd0;
	localparam logic [1:0] ACT_TRAIN  = 2'd1;
	localparam logic [1:0] ACT_TEST   = 2'd2;
	localparam logic [1:0] ACT_UNUSED = 2'd3;

	localparam logic [1:0] KIND_ACK     = 2'd0;
	localparam logic [1:0] KIND_MODEL   = 2'd1;
	localparam logic [1:0] KIND_VERDICT = 2'd2;

	localparam logic CFG_MODE   = 1'b0;
	localparam logic CFG_TARGET = 1'b1;

	localparam logic [16:0] CONF_ONE = 17'h10000;

	typedef struct packed {
		logic        start;
		logic [63:0] rem0;
		logic [63:0] dvd;
		logic [63:0] den;
		logic [6:0]  iters;
	} div_req_t;

	typedef struct packed {
		logic        done;
		logic [63:0] quo;
	} div_rsp_t;

	typedef struct packed {
		logic        start;
		logic [31:0] a;
		logic [31:0] b;
	} mul_req_t;

	typedef struct packed {
		logic        done;
		logic [63:0] prod;
	} mul_rsp_t;

	typedef struct packed {
		logic        start;
		logic [63:0] v;
	} sqrt_req_t;

	typedef struct packed {
		logic        done;
		logic [31:0] root;
	} sqrt_rsp_t;

endpackage

@@ src/running_stats_outlier_test.sv @@
// Top level of the running statistics outlier test: sequencer, statistics and counters.
//
// The block learns a one-class model from training words and then grades test words.
// A training word updates a running mean and sum of squared deviations (Welford), and
// the running minimum and maximum. A training word with tlast set also fixes the model:
// mean, sample standard deviation and a model confidence under the Chebyshev (mode 0)
// or Cantelli (mode 1) bound, and returns a model-ready word. A test word returns its
// own confidence, an outlier flag, a target-class match and the updated saturating
// confusion counter for its class and prediction. A clear word empties all state but
// the configuration. Items are handled one at a time; the arithmetic is bit-serial
// through a shared restoring divider, a shift-and-add multiplier and a square-root
// unit. A training word runs the mean division and the M2 product; a final training
// word adds the variance division and the root (with two or more samples), then the
// bound; the bound, also run for a test word, takes the two squares and the fraction
// division unless it is settled without arithmetic. The next word is taken while a
// finished result still waits in the output register.
module running_stats_outlier_test (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	// code_length [31:0], class_index [35:32], zero fill [39:36]
	input  logic [rsot_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
	// action [1:0]
	input  logic [1:0]                          s_axis_tuser,
	input  logic                                s_axis_tlast,
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// mean_out [31:0], stdev_out [63:32], model_confidence [80:64],
	// sample_confidence [97:81], is_outlier [98], is_target [99],
	// count_value [131:100], zero fill [135:132]
	output logic [rsot_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
	// result_kind [1:0]
	output logic [1:0]                          m_axis_tuser,
	input  logic                                cfg_we,
	input  logic                                cfg_index,
	input  logic [3:0]                          cfg_data
);

	localparam logic [4:0] ST_IDLE    = 5'd0;
	localparam logic [4:0] ST_MEAN_GO = 5'd1;
	localparam logic [4:0] ST_MEAN_W  = 5'd2;
	localparam logic [4:0] ST_M2_GO   = 5'd3;
	localparam logic [4:0] ST_M2_W    = 5'd4;
	localparam logic [4:0] ST_VAR_GO  = 5'd5;
	localparam logic [4:0] ST_VAR_W   = 5'd6;
	localparam logic [4:0] ST_SQRT_GO = 5'd7;
	localparam logic [4:0] ST_SQRT_W  = 5'd8;
	localparam logic [4:0] ST_FIT_DEV = 5'd9;
	localparam logic [4:0] ST_BND     = 5'd10;
	localparam logic [4:0] ST_SQA_GO  = 5'd11;
	localparam logic [4:0] ST_SQA_W   = 5'd12;
	localparam logic [4:0] ST_SQB_GO  = 5'd13;
	localparam logic [4:0] ST_SQB_W   = 5'd14;
	localparam logic [4:0] ST_FRAC_GO = 5'd15;
	localparam logic [4:0] ST_FRAC_W  = 5'd16;
	localparam logic [4:0] ST_BND_END = 5'd17;
	localparam logic [4:0] ST_CNT_RD  = 5'd18;
	localparam logic [4:0] ST_CNT_WR  = 5'd19;
	localparam logic [4:0] ST_OUT     = 5'd20;

	logic [4:0] state_q;

	// Configuration registers.
	logic       mode_q;
	logic [3:0] tgt_cls_q;

	// Statistics and model.
	logic [31:0] count_q;
	logic [31:0] mean_q;
	logic [63:0] m2_q;
	logic [31:0] min_q;
	logic [31:0] max_q;
	logic [31:0] mmean_q;
	logic [31:0] mstd_q;
	logic [16:0] mconf_q;

	// The word in hand.
	logic [1:0]  act_q;
	logic [31:0] len_q;
	logic [3:0]  cls_q;
	logic        last_q;

	// Working registers.
	logic [31:0] dmag_q;
	logic [31:0] sd_q;
	logic [31:0] dev_q;
	logic [31:0] sa_q;
	logic [31:0] sb_q;
	logic [63:0] n2_q;
	logic [63:0] d2_q;
	logic [16:0] conf_q;
	logic        pred_q;

	// Result held for the output register.
	logic [1:0]  res_kind_q;
	logic        res_tgt_q;
	logic [31:0] res_cnt_q;

	// Output register.
	logic                               m_valid_q;
	logic [rsot_pkg::OUT_TDATA_W-1:0]   m_data_q;
	logic [1:0]                         m_user_q;

	// Confusion counters.
	logic [31:0]                  cnt_mem [rsot_pkg::CNT_DEPTH];
	logic [rsot_pkg::CNT_DEPTH-1:0] cnt_vld_q;
	logic [31:0]                  cnt_rd_q;
	logic [4:0]                   cnt_idx_raw;
	logic [rsot_pkg::CNT_AW-1:0]  cnt_idx;
	logic                         cnt_we;
	logic [31:0]                  cnt_old;
	logic [31:0]                  cnt_new;
	logic                         cls_ok;

	rsot_pkg::div_req_t  div_req;
	rsot_pkg::div_rsp_t  div_rsp;
	rsot_pkg::mul_req_t  mul_req;
	rsot_pkg::mul_rsp_t  mul_rsp;
	rsot_pkg::sqrt_req_t sqrt_req;
	rsot_pkg::sqrt_rsp_t sqrt_rsp;

	logic        s_acc;
	logic [31:0] in_len;
	logic [31:0] in_dev;
	logic        delta_neg;
	logic [31:0] delta_mag;
	logic [31:0] mean_new;
	logic [31:0] after_mag;
	logic [64:0] m2_sum;
	logic [31:0] fit_d_min;
	logic [31:0] fit_d_max;
	logic [31:0] fit_dev;
	logic        norm_sh;
	logic [63:0] d2_sum;
	logic [31:0] cnt_next_n;

	assign s_acc         = s_axis_tvalid && s_axis_tready;
	assign s_axis_tready = state_q == ST_IDLE;
	assign in_len        = s_axis_tdata[31:0];

	// Deviation of a test word from the model mean; Cantelli only looks above it.
	always_comb begin
		if (in_len > mmean_q) begin
			in_dev = in_len - mmean_q;
		end else if (!mode_q) begin
			in_dev = mmean_q - in_len;
		end else begin
			in_dev = '0;
		end
	end

	// Welford step: signed delta against the old mean, then against the new one.
	assign delta_neg  = len_q < mean_q;
	assign delta_mag  = delta_neg ? mean_q - len_q : len_q - mean_q;
	assign mean_new   = delta_neg ? mean_q - div_rsp.quo[31:0] : mean_q + div_rsp.quo[31:0];
	assign after_mag  = len_q < mean_q ? mean_q - len_q : len_q - mean_q;
	assign m2_sum     = {1'b0, m2_q} + {1'b0, mul_rsp.prod};
	assign cnt_next_n = (count_q == '1) ? count_q : count_q + 32'd1;

	// Model deviation.
	assign fit_d_min = min_q >= mean_q ? min_q - mean_q : mean_q - min_q;
	assign fit_d_max = max_q >= mean_q ? max_q - mean_q : mean_q - max_q;
	always_comb begin
		if (mode_q) begin
			fit_dev = max_q > mean_q ? max_q - mean_q : '0;
		end else begin
			fit_dev = fit_d_min > fit_d_max ? fit_d_min : fit_d_max;
		end
	end

	// Both operands are 32 bits, so one shift at most brings them below 2^31.
	assign norm_sh = sd_q[31] | dev_q[31];
	assign d2_sum  = mul_rsp.prod + (mode_q ? n2_q : 64'd0);

	// Requests to the serial units.
	always_comb begin
		div_req       = '0;
		mul_req       = '0;
		sqrt_req      = '0;
		case (state_q)
			ST_MEAN_GO: begin
				div_req.start = 1'b1;
				div_req.dvd   = {delta_mag, 32'd0};
				div_req.den   = {32'd0, count_q};
				div_req.iters = 7'd32;
			end
			ST_VAR_GO: begin
				div_req.start = 1'b1;
				div_req.dvd   = m2_q;
				div_req.den   = {32'd0, count_q - 32'd1};
				div_req.iters = 7'd64;
			end
			ST_FRAC_GO: begin
				div_req.start = 1'b1;
				div_req.rem0  = n2_q;
				div_req.den   = d2_q;
				div_req.iters = 7'd16;
			end
			ST_M2_GO: begin
				mul_req.start = 1'b1;
				mul_req.a     = dmag_q;
				mul_req.b     = after_mag;
			end
			ST_SQA_GO: begin
				mul_req.start = 1'b1;
				mul_req.a     = sa_q;
				mul_req.b     = sa_q;
			end
			ST_SQB_GO: begin
				mul_req.start = 1'b1;
				mul_req.a     = sb_q;
				mul_req.b     = sb_q;
			end
			ST_SQRT_GO: begin
				sqrt_req.start = 1'b1;
				sqrt_req.v     = div_rsp.quo;
			end
			default: begin
			end
		endcase
	end

	rsot_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	rsot_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mul_req),
		.rsp    (mul_rsp)
	);

	rsot_sqrt u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (sqrt_req),
		.rsp    (sqrt_rsp)
	);

	// Counter index is class * 2 + prediction.
	assign cnt_idx_raw = {cls_q, pred_q};
	assign cnt_idx     = rsot_pkg::CNT_AW'(cnt_idx_raw);
	assign cls_ok      = 32'(cls_q) < 32'(rsot_pkg::NUM_CLASSES);
	assign cnt_we      = state_q == ST_CNT_WR;
	assign cnt_old     = cnt_vld_q[cnt_idx] ? cnt_rd_q : 32'd0;
	assign cnt_new     = (cnt_old == '1) ? cnt_old : cnt_old + 32'd1;

	always_ff @(posedge clk) begin
		if (cnt_we) begin
			cnt_mem[cnt_idx] <= cnt_new;
		end
		cnt_rd_q <= cnt_mem[cnt_idx];
	end

	// Configuration port.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= 1'b0;
			tgt_cls_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				rsot_pkg::CFG_MODE:   mode_q    <= cfg_data[0];
				rsot_pkg::CFG_TARGET: tgt_cls_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Sequencer and statistics.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			count_q    <= '0;
			mean_q     <= '0;
			m2_q       <= '0;
			min_q      <= '1;
			max_q      <= '0;
			mmean_q    <= '0;
			mstd_q     <= '0;
			mconf_q    <= '0;
			cnt_vld_q  <= '0;
			act_q      <= rsot_pkg::ACT_CLEAR;
			len_q      <= '0;
			cls_q      <= '0;
			last_q     <= 1'b0;
			dmag_q     <= '0;
			sd_q       <= '0;
			dev_q      <= '0;
			sa_q       <= '0;
			sb_q       <= '0;
			n2_q       <= '0;
			d2_q       <= '0;
			conf_q     <= '0;
			pred_q     <= 1'b0;
			res_kind_q <= rsot_pkg::KIND_ACK;
			res_tgt_q  <= 1'b0;
			res_cnt_q  <= '0;
			m_valid_q  <= 1'b0;
			m_data_q   <= '0;
			m_user_q   <= '0;
		end else begin
			// In the output state the register is either reloaded or kept full.
			if (m_valid_q && m_axis_tready && state_q != ST_OUT) begin
				m_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (s_acc) begin
						act_q  <= s_axis_tuser;
						len_q  <= in_len;
						cls_q  <= s_axis_tdata[35:32];
						last_q <= s_axis_tlast;
						case (s_axis_tuser)
							rsot_pkg::ACT_CLEAR: begin
								count_q    <= '0;
								mean_q     <= '0;
								m2_q       <= '0;
								min_q      <= '1;
								max_q      <= '0;
								mmean_q    <= '0;
								mstd_q     <= '0;
								mconf_q    <= '0;
								cnt_vld_q  <= '0;
								res_kind_q <= rsot_pkg::KIND_ACK;
								state_q    <= ST_OUT;
							end
							rsot_pkg::ACT_TRAIN: begin
								count_q <= cnt_next_n;
								if (in_len < min_q) begin
									min_q <= in_len;
								end
								if (in_len > max_q) begin
									max_q <= in_len;
								end
								state_q <= ST_MEAN_GO;
							end
							rsot_pkg::ACT_TEST: begin
								sd_q    <= mstd_q;
								dev_q   <= in_dev;
								state_q <= ST_BND;
							end
							default: begin
								res_kind_q <= rsot_pkg::KIND_ACK;
								state_q    <= ST_OUT;
							end
						endcase
					end
				end
				ST_MEAN_GO: state_q <= ST_MEAN_W;
				ST_MEAN_W: begin
					if (div_rsp.done) begin
						mean_q  <= mean_new;
						dmag_q  <= delta_mag;
						state_q <= ST_M2_GO;
					end
				end
				ST_M2_GO: state_q <= ST_M2_W;
				ST_M2_W: begin
					if (mul_rsp.done) begin
						m2_q <= m2_sum[64] ? '1 : m2_sum[63:0];
						if (last_q) begin
							mmean_q <= mean_q;
							if (count_q >= 32'd2) begin
								state_q <= ST_VAR_GO;
							end else begin
								mstd_q  <= '0;
								state_q <= ST_FIT_DEV;
							end
						end else begin
							res_kind_q <= rsot_pkg::KIND_ACK;
							state_q    <= ST_OUT;
						end
					end
				end
				ST_VAR_GO: state_q <= ST_VAR_W;
				ST_VAR_W: begin
					if (div_rsp.done) begin
						state_q <= ST_SQRT_GO;
					end
				end
				ST_SQRT_GO: state_q <= ST_SQRT_W;
				ST_SQRT_W: begin
					if (sqrt_rsp.done) begin
						mstd_q  <= sqrt_rsp.root;
						state_q <= ST_FIT_DEV;
					end
				end
				ST_FIT_DEV: begin
					sd_q    <= mstd_q;
					dev_q   <= fit_dev;
					state_q <= ST_BND;
				end
				ST_BND: begin
					// Zero deviation, zero spread, and Chebyshev with spread at least
					// the deviation are settled without arithmetic.
					if (dev_q == '0) begin
						conf_q  <= rsot_pkg::CONF_ONE;
						state_q <= ST_BND_END;
					end else if (sd_q == '0) begin
						conf_q  <= '0;
						state_q <= ST_BND_END;
					end else if (!mode_q && sd_q >= dev_q) begin
						conf_q  <= rsot_pkg::CONF_ONE;
						state_q <= ST_BND_END;
					end else begin
						sa_q    <= norm_sh ? {1'b0, sd_q[31:1]} : sd_q;
						sb_q    <= norm_sh ? {1'b0, dev_q[31:1]} : dev_q;
						state_q <= ST_SQA_GO;
					end
				end
				ST_SQA_GO: state_q <= ST_SQA_W;
				ST_SQA_W: begin
					if (mul_rsp.done) begin
						n2_q    <= mul_rsp.prod;
						state_q <= ST_SQB_GO;
					end
				end
				ST_SQB_GO: state_q <= ST_SQB_W;
				ST_SQB_W: begin
					if (mul_rsp.done) begin
						d2_q <= d2_sum;
						if (d2_sum == '0 || n2_q >= d2_sum) begin
							conf_q  <= rsot_pkg::CONF_ONE;
							state_q <= ST_BND_END;
						end else begin
							state_q <= ST_FRAC_GO;
						end
					end
				end
				ST_FRAC_GO: state_q <= ST_FRAC_W;
				ST_FRAC_W: begin
					if (div_rsp.done) begin
						conf_q  <= {1'b0, div_rsp.quo[15:0]};
						state_q <= ST_BND_END;
					end
				end
				ST_BND_END: begin
					if (act_q == rsot_pkg::ACT_TRAIN) begin
						mconf_q    <= conf_q;
						res_kind_q <= rsot_pkg::KIND_MODEL;
						state_q    <= ST_OUT;
					end else begin
						pred_q     <= conf_q < mconf_q;
						res_tgt_q  <= cls_q == tgt_cls_q;
						res_kind_q <= rsot_pkg::KIND_VERDICT;
						if (cls_ok) begin
							state_q <= ST_CNT_RD;
						end else begin
							res_cnt_q <= '0;
							state_q   <= ST_OUT;
						end
					end
				end
				ST_CNT_RD: state_q <= ST_CNT_WR;
				ST_CNT_WR: begin
					cnt_vld_q[cnt_idx] <= 1'b1;
					res_cnt_q          <= cnt_new;
					state_q            <= ST_OUT;
				end
				ST_OUT: begin
					if (!m_valid_q || m_axis_tready) begin
						m_valid_q <= 1'b1;
						m_user_q  <= res_kind_q;
						case (res_kind_q)
							rsot_pkg::KIND_MODEL: begin
								m_data_q <= {55'd0, mconf_q, mstd_q, mmean_q};
							end
							rsot_pkg::KIND_VERDICT: begin
								m_data_q <= {4'd0, res_cnt_q, res_tgt_q, pred_q,
									conf_q, mconf_q, mstd_q, mmean_q};
							end
							default: begin
								m_data_q <= '0;
							end
						endcase
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;
	assign m_axis_tuser  = m_user_q;

endmodule

@@ src/rsot_div.sv @@
// Bit-serial restoring divider, one quotient bit per cycle.
module rsot_div (
	input  logic               clk,
	input  logic               arst_n,
	input  rsot_pkg::div_req_t req,
	output rsot_pkg::div_rsp_t rsp
);

	logic [63:0] rem_q;
	logic [63:0] dvd_q;
	logic [63:0] den_q;
	logic [63:0] quo_q;
	logic [6:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [64:0] shifted;
	logic        ge;
	logic [64:0] diff;

	assign shifted = {rem_q, dvd_q[63]};
	assign ge      = shifted >= {1'b0, den_q};
	assign diff    = shifted - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= req.iters;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 7'd1;
				if (cnt_q == 7'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= req.rem0;
			dvd_q <= req.dvd;
			den_q <= req.den;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? diff[63:0] : shifted[63:0];
			dvd_q <= {dvd_q[62:0], 1'b0};
			quo_q <= {quo_q[62:0], ge};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo  = quo_q;

endmodule

@@ src/rsot_mul.sv @@
// Bit-serial shift-and-add multiplier, 32 by 32 bits, one multiplier bit per cycle.
module rsot_mul (
	input  logic               clk,
	input  logic               arst_n,
	input  rsot_pkg::mul_req_t req,
	output rsot_pkg::mul_rsp_t rsp
);

	logic [63:0] acc_q;
	logic [63:0] mc_q;
	logic [31:0] mp_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic        done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'd32;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			acc_q <= '0;
			mc_q  <= {32'd0, req.a};
			mp_q  <= req.b;
		end else if (busy_q) begin
			if (mp_q[0]) begin
				acc_q <= acc_q + mc_q;
			end
			mc_q <= {mc_q[62:0], 1'b0};
			mp_q <= {1'b0, mp_q[31:1]};
		end
	end

	assign rsp.done = done_q;
	assign rsp.prod = acc_q;

endmodule

@@ src/rsot_sqrt.sv @@
// Digit-serial integer square root, one root bit (two radicand bits) per cycle.
module rsot_sqrt (
	input  logic                clk,
	input  logic                arst_n,
	input  rsot_pkg::sqrt_req_t req,
	output rsot_pkg::sqrt_rsp_t rsp
);

	logic [63:0] v_q;
	logic [34:0] rem_q;
	logic [31:0] root_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [34:0] rem_sh;
	logic [34:0] trial;
	logic        ge;

	assign rem_sh = {rem_q[32:0], v_q[63:62]};
	assign trial  = {1'b0, root_q, 2'b01};
	assign ge     = rem_sh >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'd32;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			v_q    <= req.v;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			v_q    <= {v_q[61:0], 2'b00};
			rem_q  <= ge ? rem_sh - trial : rem_sh;
			root_q <= {root_q[30:0], ge};
		end
	end

	assign rsp.done = done_q;
	assign rsp.root = root_q;

endmodule

@@ src/rsot_check.sv @@
// Port-level checker of the running statistics outlier test, bound to the top level.
`include "running_stats_outlier_test_assert.svh"

module rsot_check (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             s_axis_tvalid,
	input logic                             s_axis_tready,
	input logic                             m_axis_tvalid,
	input logic                             m_axis_tready,
	input logic [rsot_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
	input logic [1:0]                       m_axis_tuser
);

	`RSOT_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
	`RSOT_ASSERT_NEXT(a_one_item, s_axis_tvalid && s_axis_tready, !s_axis_tready)
	`RSOT_ASSERT_NOW(a_ack_zero, m_axis_tvalid && m_axis_tuser == rsot_pkg::KIND_ACK, m_axis_tdata == '0)
	`RSOT_ASSERT_NOW(a_conf_sat, m_axis_tvalid, m_axis_tdata[97:81] <= rsot_pkg::CONF_ONE)
	`RSOT_ASSERT_NOW(a_outlier, m_axis_tvalid && m_axis_tdata[98], m_axis_tdata[97:81] < m_axis_tdata[80:64])

endmodule

bind running_stats_outlier_test rsot_check u_rsot_check (.*);
